[rtl/core/lre_pkg.sv]
package lre_pkg;

    localparam int COUNTER_BITS = 48;
    localparam int FRAC_BITS    = 8;
    localparam int INTERVAL     = 10;

    localparam int COUNT_W = 48;
    localparam int RATE_W  = 56;
    localparam int SHIFT_W = 3;
    localparam int PERIOD_W = 8;

    localparam int S_DATA_W = 2 * COUNT_W;
    localparam int M_DATA_W = 8 * RATE_W;
    localparam int M_USER_W = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [SHIFT_W-1:0]  RATE_SHIFT_RST     = SHIFT_W'(3);
    localparam logic [SHIFT_W-1:0]  MAX_SHIFT_RST      = SHIFT_W'(3);
    localparam logic [PERIOD_W-1:0] PERIOD_SAMPLES_RST = PERIOD_W'(30);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE_SHIFT,
        CFG_MAX_SHIFT,
        CFG_PERIOD_SAMPLES
    } t_cfg_idx;

    // constant divider: long division by INTERVAL, one STEP_BITS-wide digit per stage;
    // each digit quotient comes from a reciprocal multiply (exact while acc * err < 2^shift)
    localparam int DIV_W       = COUNTER_BITS + FRAC_BITS;
    localparam int STEP_BITS   = 16;
    localparam int DIV_STAGES  = (DIV_W + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W       = DIV_STAGES * STEP_BITS;
    localparam int REM_W       = $clog2(INTERVAL + 1);
    localparam int ACC_W       = REM_W + STEP_BITS;
    localparam int RECIP_SHIFT = ACC_W + REM_W;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(INTERVAL) - 64'd1) / 64'(INTERVAL));

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [PAD_W-1:0] num;
    } t_div;

    function automatic t_div div_step(t_div d);
        logic [ACC_W-1:0]         acc;
        logic [ACC_W+RECIP_W-1:0] prod;
        logic [STEP_BITS-1:0]     q;
        t_div                     o;
        acc   = {d.rem, d.num[PAD_W-1 -: STEP_BITS]};
        prod  = (ACC_W+RECIP_W)'(acc) * (ACC_W+RECIP_W)'(RECIP);
        q     = STEP_BITS'(prod >> RECIP_SHIFT);
        o.num = {d.num[PAD_W-STEP_BITS-1:0], q};
        o.rem = REM_W'(acc - ACC_W'(q) * ACC_W'(INTERVAL));
        return o;
    endfunction

    // (x + (2^k - 1) * old) >> k
    function automatic logic [RATE_W-1:0] ewma(logic [RATE_W-1:0] x,
                                               logic [RATE_W-1:0] old,
                                               logic [SHIFT_W-1:0] k);
        logic [RATE_W+7:0] sum;
        sum = {8'd0, x} + ({8'd0, old} << k) - {8'd0, old};
        return RATE_W'(sum >> k);
    endfunction

endpackage

[rtl/core/link_rate_estimator.sv]
// Link rate estimator.
// Input stream: one transfer per tick carries the transmit and receive byte
// counters. Output stream: one transfer per input transfer carries the rate,
// smoothed rate, period maximum and smoothed maximum for both directions,
// plus period_end and first_reading flags in tuser.
// Configuration: a plain write port (rate_shift, max_shift, period_samples);
// the user must write it only while the block is idle, which the block does not enforce.
// Pipeline: the input register, DIV_STAGES divide stages and the output
// register; DIV_STAGES follows from the 48-bit counters and 8 fraction bits,
// since the divide by INTERVAL retires one 16-bit quotient digit per stage.
// Throughput: one transfer per cycle unless stalled; the averages and the period
// maximum are updated in the single output stage, so items follow back to back.
// Reset: all averages, maxima and the period count clear, the configuration
// returns to its defaults and the next tick only primes the counters.
// Stall: when the output is valid and not taken, the whole pipeline holds
// and s_axis_tready drops; nothing is lost or repeated.
module link_rate_estimator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lre_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lre_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tx_count, rx_count
    input  logic [lre_pkg::S_DATA_W-1:0]      s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tx_rate, tx_smooth_rate, tx_period_max, tx_smooth_max,
    // rx_rate, rx_smooth_rate, rx_period_max, rx_smooth_max
    output logic [lre_pkg::M_DATA_W-1:0]      m_axis_tdata,
    // period_end, first_reading
    output logic [lre_pkg::M_USER_W-1:0]      m_axis_tuser
);
    import lre_pkg::*;

    logic [SHIFT_W-1:0]  r_rate_shift;
    logic [SHIFT_W-1:0]  r_max_shift;
    logic [PERIOD_W-1:0] r_period_samples;

    logic                    r_primed;
    logic [COUNTER_BITS-1:0] r_tx_last;
    logic [COUNTER_BITS-1:0] r_rx_last;

    logic r_vld   [0:DIV_STAGES];
    logic r_first [0:DIV_STAGES];
    t_div r_tx_div[0:DIV_STAGES];
    t_div r_rx_div[0:DIV_STAGES];

    logic [PERIOD_W-1:0] r_tick;
    logic [RATE_W-1:0]   r_tx_sm, r_tx_mx, r_tx_ms;
    logic [RATE_W-1:0]   r_rx_sm, r_rx_mx, r_rx_ms;

    logic                r_out_vld;
    logic [M_DATA_W-1:0] r_out_data;
    logic [M_USER_W-1:0] r_out_user;

    logic                    advance;
    logic                    accept;
    logic [COUNTER_BITS-1:0] tx_delta, rx_delta;

    logic [PERIOD_W-1:0] n_tick;
    logic                close;
    logic [RATE_W-1:0]   tx_r, tx_sm, tx_hi, tx_mx, tx_ms;
    logic [RATE_W-1:0]   rx_r, rx_sm, rx_hi, rx_mx, rx_ms;

    assign advance       = !r_out_vld || m_axis_tready;
    assign accept        = s_axis_tvalid && advance;
    assign s_axis_tready = advance;

    assign tx_delta = s_axis_tdata[COUNTER_BITS-1:0] - r_tx_last;
    assign rx_delta = s_axis_tdata[COUNT_W+COUNTER_BITS-1:COUNT_W] - r_rx_last;

    always_comb begin
        n_tick = r_tick + PERIOD_W'(1);
        close  = (n_tick == r_period_samples);

        tx_r  = RATE_W'(r_tx_div[DIV_STAGES].num);
        tx_sm = ewma(tx_r, r_tx_sm, r_rate_shift);
        tx_hi = (tx_r > r_tx_mx) ? tx_r : r_tx_mx;
        tx_ms = close ? ewma(tx_hi, r_tx_ms, r_max_shift) : r_tx_ms;
        tx_mx = close ? tx_r : tx_hi;

        rx_r  = RATE_W'(r_rx_div[DIV_STAGES].num);
        rx_sm = ewma(rx_r, r_rx_sm, r_rate_shift);
        rx_hi = (rx_r > r_rx_mx) ? rx_r : r_rx_mx;
        rx_ms = close ? ewma(rx_hi, r_rx_ms, r_max_shift) : r_rx_ms;
        rx_mx = close ? rx_r : rx_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_shift     <= RATE_SHIFT_RST;
            r_max_shift      <= MAX_SHIFT_RST;
            r_period_samples <= PERIOD_SAMPLES_RST;
            r_primed         <= 1'b0;
            r_tx_last        <= '0;
            r_rx_last        <= '0;
            for (int k = 0; k <= DIV_STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_tick    <= '0;
            r_tx_sm   <= '0;
            r_tx_mx   <= '0;
            r_tx_ms   <= '0;
            r_rx_sm   <= '0;
            r_rx_mx   <= '0;
            r_rx_ms   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RATE_SHIFT:     r_rate_shift     <= i_cfg_wdata[SHIFT_W-1:0];
                    CFG_MAX_SHIFT:      r_max_shift      <= i_cfg_wdata[SHIFT_W-1:0];
                    CFG_PERIOD_SAMPLES: r_period_samples <= i_cfg_wdata[PERIOD_W-1:0];
                    default: ;
                endcase
            end

            if (advance) begin
                r_vld[0]       <= accept;
                r_first[0]     <= !r_primed;
                r_tx_div[0]    <= '{rem: '0, num: PAD_W'(tx_delta) << FRAC_BITS};
                r_rx_div[0]    <= '{rem: '0, num: PAD_W'(rx_delta) << FRAC_BITS};
                for (int k = 1; k <= DIV_STAGES; k++) begin
                    r_vld[k]    <= r_vld[k-1];
                    r_first[k]  <= r_first[k-1];
                    r_tx_div[k] <= div_step(r_tx_div[k-1]);
                    r_rx_div[k] <= div_step(r_rx_div[k-1]);
                end

                if (accept) begin
                    r_primed  <= 1'b1;
                    r_tx_last <= s_axis_tdata[COUNTER_BITS-1:0];
                    r_rx_last <= s_axis_tdata[COUNT_W+COUNTER_BITS-1:COUNT_W];
                end

                r_out_vld <= r_vld[DIV_STAGES];
                if (r_vld[DIV_STAGES]) begin
                    if (r_first[DIV_STAGES]) begin
                        r_out_data <= '0;
                        r_out_user <= 2'b10;
                    end else begin
                        r_tick     <= close ? '0 : n_tick;
                        r_tx_sm    <= tx_sm;
                        r_tx_mx    <= tx_mx;
                        r_tx_ms    <= tx_ms;
                        r_rx_sm    <= rx_sm;
                        r_rx_mx    <= rx_mx;
                        r_rx_ms    <= rx_ms;
                        r_out_data <= {rx_ms, rx_mx, rx_sm, rx_r, tx_ms, tx_mx, tx_sm, tx_r};
                        r_out_user <= {1'b0, close};
                    end
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

[rtl/core/lre_checker.sv]
module lre_port_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [lre_pkg::M_DATA_W-1:0]      m_axis_tdata,
    input  logic [lre_pkg::M_USER_W-1:0]      m_axis_tuser
);
    import lre_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0 && !m_axis_tuser[0])
        else $error("priming transfer carries data");

    a_max_ge_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            m_axis_tdata[3*RATE_W-1:2*RATE_W] >= m_axis_tdata[RATE_W-1:0] &&
            m_axis_tdata[7*RATE_W-1:6*RATE_W] >= m_axis_tdata[5*RATE_W-1:4*RATE_W])
        else $error("period maximum below current rate");

endmodule

bind link_rate_estimator lre_port_checker u_lre_checker (.*);
